>>> hdl/udpc_pkg.sv
// Shared constants, tables and helpers for the up/down prime counter display.
// No dependencies; imported by the top level and the port checker.
package udpc_pkg;

  // Field widths
  localparam int CountW  = 7;
  localparam int SegW    = 7;
  localparam int IdxW    = 5;
  localparam int TempW   = 10;
  localparam int CfgW    = 8;
  localparam int InDataW  = 16;  // 13 bits of fields, padded to bytes
  localparam int OutDataW = 24;  // 22 bits of fields, padded to bytes

  // Prime table size (table holds the first 25 primes)
  localparam int PRIME_COUNT_DEF = 25;
  localparam int PRIME_TABLE_MAX = 25;

  // Counter limits
  localparam logic [CountW-1:0] COUNT_MAX = 7'd99;

  // Configuration register indexes
  localparam logic CFG_TEMP_LOW  = 1'b0;
  localparam logic CFG_TEMP_HIGH = 1'b1;

  // Config reset values
  localparam logic [CfgW-1:0] TEMP_LOW_RST  = 8'd0;
  localparam logic [CfgW-1:0] TEMP_HIGH_RST = 8'd31;

  // Temperature scaling T = (s - 20) * 165 / 338 - 40, truncated toward zero.
  // Divide by 338 is a multiply by a rounded-up reciprocal; exact for the
  // 18-bit product range.
  localparam int TEMP_OFS   = 20;
  localparam int TEMP_NUM   = 165;
  localparam int TEMP_DEN   = 338;
  localparam int TEMP_BASE  = 40;
  localparam int RECIP_SH   = 27;
  localparam int RECIP      = ((2 ** RECIP_SH) + TEMP_DEN - 1) / TEMP_DEN;
  localparam int SCALE_W    = 26;
  localparam logic [SCALE_W-1:0] SCALE_MUL = SCALE_W'(TEMP_NUM * RECIP);
  localparam int QUOT_W     = 9;   // max quotient 489
  localparam int TEMP_SW    = 11;  // signed scaled temperature

  // Digit split: cnt / 10 == (cnt * 103) >> 10 for cnt <= 99
  localparam logic [6:0] TENS_MUL = 7'd103;
  localparam int TENS_SH = 10;

  function automatic logic [CountW-1:0] prime_at(input logic [IdxW-1:0] idx);
    logic [CountW-1:0] p;
    case (idx)
      5'd0:    p = 7'd2;
      5'd1:    p = 7'd3;
      5'd2:    p = 7'd5;
      5'd3:    p = 7'd7;
      5'd4:    p = 7'd11;
      5'd5:    p = 7'd13;
      5'd6:    p = 7'd17;
      5'd7:    p = 7'd19;
      5'd8:    p = 7'd23;
      5'd9:    p = 7'd29;
      5'd10:   p = 7'd31;
      5'd11:   p = 7'd37;
      5'd12:   p = 7'd41;
      5'd13:   p = 7'd43;
      5'd14:   p = 7'd47;
      5'd15:   p = 7'd53;
      5'd16:   p = 7'd59;
      5'd17:   p = 7'd61;
      5'd18:   p = 7'd67;
      5'd19:   p = 7'd71;
      5'd20:   p = 7'd73;
      5'd21:   p = 7'd79;
      5'd22:   p = 7'd83;
      5'd23:   p = 7'd89;
      default: p = 7'd97;
    endcase
    return p;
  endfunction

  // Segment patterns, bit0 = a .. bit6 = g; nine has no d
  function automatic logic [SegW-1:0] seg_of(input logic [3:0] digit);
    logic [SegW-1:0] s;
    case (digit)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      default: s = 7'h67;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/updown_prime_counter_display_top.sv
// Up/down counter and prime stepper with seven-segment and motor enable outputs.
// Depends on udpc_pkg.
//
// channel | dir | handshake        | payload
// s_*     | in  | s_tvalid/tready  | s_tdata: prime_mode, up_level, down_level, temp_sample
// m_*     | out | m_tvalid/tready  | m_tdata: count_value, tens/units segments, motor_on
// cfg_*   | in  | cfg_we           | cfg_index selects low/high bound, cfg_data
//
// One tick per clock sustained while the output is not stalled; a tick reaches the output
// through the input register, then the result register.
// The counter state updates as a tick moves from the input to the result register.
// A stalled output holds its beat; the input register still takes one more tick.
// rst is synchronous: counter, arm bits, bounds and both valids return to reset.
module updown_prime_counter_display_top
  import udpc_pkg::*;
#(
  parameter int PRIME_COUNT = PRIME_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // [0] prime_mode, [1] up_level, [2] down_level, [12:3] temp_sample, [15:13] zero
  input  logic [InDataW-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // [6:0] count_value, [13:7] tens_segments, [20:14] units_segments,
  // [21] motor_on, [23:22] zero
  output logic [OutDataW-1:0] m_tdata,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CfgW-1:0]     cfg_data
);

  localparam logic [IdxW-1:0] LAST_IDX = IdxW'(PRIME_COUNT - 1);

  // Config registers
  logic [CfgW-1:0] motor_temp_low;
  logic [CfgW-1:0] motor_temp_high;

  // Input stage
  logic             in_valid;
  logic             in_mode;
  logic             in_up;
  logic             in_down;
  logic [TempW-1:0] in_temp;

  // Counter state
  logic              last_mode;
  logic [CountW-1:0] count_reg, count_next;
  logic [IdxW-1:0]   prime_index, prime_index_next;
  logic              up_armed, up_armed_next;
  logic              down_armed, down_armed_next;

  // Result stage
  logic [CountW-1:0] count_value;
  logic [SegW-1:0]   tens_segments, units_segments;
  logic              motor_on;

  logic advance;

  logic              up_arm_v, down_arm_v, key_up, key_dn;
  logic [IdxW-1:0]   idx_safe, idx_step;
  logic [13:0]       tens_prod;
  logic [3:0]        tens_digit, units_digit;
  logic [CountW-1:0] tens_x10;
  logic [SegW-1:0]   tens_seg_next, units_seg_next;
  logic              temp_neg;
  logic [TempW-1:0]  temp_mag;
  logic [TempW+SCALE_W-1:0] temp_prod;
  logic [QUOT_W-1:0] temp_quot;
  logic signed [TEMP_SW-1:0] temp_val;
  logic              motor_next;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      motor_temp_low  <= TEMP_LOW_RST;
      motor_temp_high <= TEMP_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEMP_LOW:  motor_temp_low  <= cfg_data;
        CFG_TEMP_HIGH: motor_temp_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= s_tdata[0];
      in_up   <= s_tdata[1];
      in_down <= s_tdata[2];
      in_temp <= s_tdata[12:3];
    end
  end

  // Button edges, count and prime index update
  always_comb begin
    up_arm_v   = up_armed || in_up;
    down_arm_v = down_armed || in_down;
    key_up     = !in_up && up_arm_v;
    key_dn     = !key_up && !in_down && down_arm_v;

    idx_safe = (prime_index >= LAST_IDX) ? LAST_IDX : prime_index;
    if (key_up) begin
      idx_step = (idx_safe >= LAST_IDX) ? '0 : idx_safe + 1'b1;
    end else begin
      idx_step = (idx_safe == '0) ? LAST_IDX : idx_safe - 1'b1;
    end

    count_next       = count_reg;
    prime_index_next = prime_index;
    up_armed_next    = up_armed;
    down_armed_next  = down_armed;

    if (in_mode != last_mode) begin
      // mode change: restart, buttons ignored this tick
      if (!in_mode) begin
        count_next = '0;
      end else begin
        prime_index_next = '0;
        count_next       = prime_at('0);
      end
    end else begin
      up_armed_next   = key_up ? 1'b0 : up_arm_v;
      down_armed_next = key_dn ? 1'b0 : down_arm_v;
      if (!in_mode) begin
        if (key_up) begin
          count_next = (count_reg >= COUNT_MAX) ? '0 : count_reg + 1'b1;
        end else if (key_dn) begin
          count_next = (count_reg == '0 || count_reg > COUNT_MAX) ? COUNT_MAX
                                                                  : count_reg - 1'b1;
        end
      end else if (key_up || key_dn) begin
        prime_index_next = idx_step;
        count_next       = prime_at(idx_step);
      end
    end
  end

  // Digit split and segment decode
  always_comb begin
    tens_prod      = 14'(count_next) * 14'(TENS_MUL);
    tens_digit     = tens_prod[TENS_SH+3:TENS_SH];
    tens_x10       = CountW'({tens_digit, 3'b000}) + CountW'({tens_digit, 1'b0});
    units_digit    = 4'(count_next - tens_x10);
    tens_seg_next  = seg_of(tens_digit);
    units_seg_next = seg_of(units_digit);
  end

  // Scaled temperature and window compare
  always_comb begin
    temp_neg  = in_temp < TempW'(TEMP_OFS);
    temp_mag  = temp_neg ? TempW'(TEMP_OFS) - in_temp : in_temp - TempW'(TEMP_OFS);
    temp_prod = (TempW+SCALE_W)'(temp_mag) * (TempW+SCALE_W)'(SCALE_MUL);
    temp_quot = temp_prod[RECIP_SH+QUOT_W-1:RECIP_SH];
    temp_val  = temp_neg ? -$signed({2'b00, temp_quot}) : $signed({2'b00, temp_quot});
    temp_val  = temp_val - TEMP_SW'(TEMP_BASE);
    motor_next = (temp_val > TEMP_SW'($signed(motor_temp_low)))
              && (temp_val < TEMP_SW'($signed(motor_temp_high)));
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_mode   <= 1'b0;
      count_reg   <= '0;
      prime_index <= '0;
      up_armed    <= 1'b1;
      down_armed  <= 1'b1;
    end else if (advance) begin
      last_mode   <= in_mode;
      count_reg   <= count_next;
      prime_index <= prime_index_next;
      up_armed    <= up_armed_next;
      down_armed  <= down_armed_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      count_value    <= count_next;
      tens_segments  <= tens_seg_next;
      units_segments <= units_seg_next;
      motor_on       <= motor_next;
    end
  end

  assign m_tdata = {2'b00, motor_on, units_segments, tens_segments, count_value};

endmodule

>>> hdl/udpc_checker.sv
// Port-level checks for the up/down prime counter display, bound to the top level.
// Depends on udpc_pkg and updown_prime_counter_display_top.
module udpc_checker
  import udpc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata
);

  // output empty right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

  // displayed count stays in range
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[6:0] <= COUNT_MAX)
    else $error("count out of range");

  // a tick taken while the output is empty shows after the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
    else $error("accepted tick did not reach output");

endmodule

bind updown_prime_counter_display_top udpc_checker u_udpc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for updown_prime_counter_display_top: streams polling ticks, predicts each display beat.
// Depends on udpc_pkg and the RTL top level; self-contained otherwise.
module tb_top;
  import udpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_TICKS = 100;

  typedef struct {
    logic       prime_mode;
    logic       up_level;
    logic       down_level;
    logic [9:0] temp_sample;
  } tick_t;

  typedef struct {
    logic [CountW-1:0] count_value;
    logic [SegW-1:0]   tens_segments;
    logic [SegW-1:0]   units_segments;
    logic              motor_on;
  } display_t;

  typedef enum int {PRESS_NONE, PRESS_UP, PRESS_DOWN} press_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_we = 1'b0;
  logic                cfg_index = CFG_TEMP_LOW;
  logic [CfgW-1:0]     cfg_data = '0;

  // Predicted counter state and bounds
  logic                   prev_mode = 1'b0;
  logic [CountW-1:0]      shown_count = '0;
  int                     prime_pos = 0;
  logic                   up_ready = 1'b1;
  logic                   down_ready = 1'b1;
  logic signed [CfgW-1:0] bound_low = 8'sd0;
  logic signed [CfgW-1:0] bound_high = 8'sd31;

  display_t expected_displays[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  bit       sender_steady = 1'b0;
  bit       receiver_steady = 1'b0;
  logic     stim_mode = 1'b0;

  updown_prime_counter_display_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // n-th prime by trial division, index 0 gives 2
  function automatic logic [CountW-1:0] nth_prime(input int idx);
    int n;
    int found;
    int d;
    bit is_p;
    found = -1;
    n = 1;
    while (found < idx) begin
      n++;
      is_p = 1'b1;
      for (d = 2; d * d <= n; d++) begin
        if (n % d == 0) is_p = 1'b0;
      end
      if (is_p) found++;
    end
    return n[CountW-1:0];
  endfunction

  // bit0 = a .. bit6 = g; nine drawn without d
  function automatic logic [SegW-1:0] digit_pattern(input int digit);
    case (digit)
      0: return 7'h3F;
      1: return 7'h06;
      2: return 7'h5B;
      3: return 7'h4F;
      4: return 7'h66;
      5: return 7'h6D;
      6: return 7'h7D;
      7: return 7'h07;
      8: return 7'h7F;
      default: return 7'h67;
    endcase
  endfunction

  // Advance the predicted counter by one tick and form its display beat
  function automatic display_t predict_display(input tick_t t);
    display_t d;
    press_t   press;
    int       sample;
    int       degrees;
    press = PRESS_NONE;
    if (t.prime_mode != prev_mode) begin
      // mode change: reset count, buttons not sampled
      if (!t.prime_mode) begin
        shown_count = '0;
      end else begin
        prime_pos = 0;
        shown_count = nth_prime(0);
      end
    end else begin
      if (t.up_level) up_ready = 1'b1;
      if (t.down_level) down_ready = 1'b1;
      if (!t.up_level && up_ready) begin
        up_ready = 1'b0;
        press = PRESS_UP;
      end else if (!t.down_level && down_ready) begin
        down_ready = 1'b0;
        press = PRESS_DOWN;
      end
      if (!t.prime_mode) begin
        if (press == PRESS_UP) begin
          shown_count = (shown_count >= COUNT_MAX) ? '0 : shown_count + 1'b1;
        end else if (press == PRESS_DOWN) begin
          shown_count = (shown_count == 0) ? COUNT_MAX : shown_count - 1'b1;
        end
      end else if (press != PRESS_NONE) begin
        if (press == PRESS_UP) begin
          prime_pos = (prime_pos + 1 >= PRIME_COUNT_DEF) ? 0 : prime_pos + 1;
        end else begin
          prime_pos = (prime_pos == 0) ? PRIME_COUNT_DEF - 1 : prime_pos - 1;
        end
        shown_count = nth_prime(prime_pos);
      end
    end
    prev_mode = t.prime_mode;

    sample = int'(t.temp_sample);
    degrees = (sample - 20) * 165 / 338 - 40;
    d.count_value = shown_count;
    d.tens_segments = digit_pattern(shown_count / 10);
    d.units_segments = digit_pattern(shown_count % 10);
    d.motor_on = (degrees > bound_low) && (degrees < bound_high);
    return d;
  endfunction

  function automatic int pick_gap(input bit steady);
    return steady ? 0 : $urandom_range(0, 11);
  endfunction

  // Send one tick beat; valid stays high afterwards so back-to-back beats need no gap
  task automatic send_tick(input tick_t t);
    int gap;
    gap = pick_gap(sender_steady);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, t.temp_sample, t.down_level, t.up_level, t.prime_mode};
    do @(posedge clk); while (!s_tready);
    expected_displays.push_back(predict_display(t));
  endtask

  task automatic tick(input logic mode, input logic up, input logic down, input int temp);
    tick_t t;
    t.prime_mode = mode;
    t.up_level = up;
    t.down_level = down;
    t.temp_sample = temp[9:0];
    send_tick(t);
  endtask

  // Bound writes only once every display beat has come back
  task automatic write_bound(input logic idx, input int value);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_displays.size() != 0);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CfgW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TEMP_LOW) bound_low = value[CfgW-1:0];
    else bound_high = value[CfgW-1:0];
  endtask

  task automatic test_count_wrap();
    tick(1'b0, 1'b1, 1'b1, 0);
    tick(1'b0, 1'b1, 1'b0, 1023);  // down from zero wraps to 99
    tick(1'b0, 1'b1, 1'b1, 512);
    tick(1'b0, 1'b0, 1'b1, 511);   // up from 99 wraps to zero
    tick(1'b0, 1'b0, 1'b1, 300);   // held, no repeat
    tick(1'b0, 1'b1, 1'b1, 200);
    tick(1'b0, 1'b0, 1'b0, 100);   // both pressed: up wins
    tick(1'b0, 1'b0, 1'b0, 100);   // down still armed, taken now
    tick(1'b0, 1'b1, 1'b1, 100);
  endtask

  task automatic test_prime_steps();
    tick(1'b1, 1'b0, 1'b0, 150);   // mode change ignores buttons
    tick(1'b1, 1'b0, 1'b0, 150);
    tick(1'b1, 1'b0, 1'b0, 150);
    tick(1'b1, 1'b1, 1'b1, 150);
    tick(1'b1, 1'b1, 1'b0, 150);   // index wraps down to the last prime
    tick(1'b1, 1'b0, 1'b1, 150);   // and back up to the first
    tick(1'b0, 1'b0, 1'b0, 150);   // leave prime mode
    tick(1'b0, 1'b1, 1'b1, 150);
  endtask

  task automatic test_temp_window();
    // default window edges, plus truncation with a negative numerator
    tick(1'b0, 1'b1, 1'b1, 19);
    tick(1'b0, 1'b1, 1'b1, 20);
    tick(1'b0, 1'b1, 1'b1, 102);
    tick(1'b0, 1'b1, 1'b1, 104);
    tick(1'b0, 1'b1, 1'b1, 164);
    tick(1'b0, 1'b1, 1'b1, 166);
    write_bound(CFG_TEMP_LOW, -40);
    write_bound(CFG_TEMP_HIGH, 125);
    tick(1'b0, 1'b1, 1'b1, 21);
    tick(1'b0, 1'b1, 1'b1, 357);
    tick(1'b0, 1'b1, 1'b1, 358);
    tick(1'b0, 1'b1, 1'b1, 1023);
    // inverted window never enables the motor
    write_bound(CFG_TEMP_LOW, 125);
    write_bound(CFG_TEMP_HIGH, -40);
    tick(1'b0, 1'b1, 1'b1, 200);
  endtask

  task automatic test_random_ticks();
    int ph;
    int lo;
    int hi;
    tick_t t;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      lo = $urandom_range(0, 165) - 40;
      hi = $urandom_range(0, 165) - 40;
      if (ph == 0 || $urandom_range(0, 3) == 0) lo = -40;
      if (ph == 0 || $urandom_range(0, 3) == 0) hi = 125;
      if (lo >= hi && $urandom_range(0, 2) != 0) begin
        lo = lo - 41;
        hi = lo + 60;
        if (lo < -40) lo = -40;
        if (hi > 125) hi = 125;
      end
      write_bound(CFG_TEMP_LOW, lo);
      write_bound(CFG_TEMP_HIGH, hi);
      sender_steady = ($urandom_range(0, 3) == 0);
      receiver_steady = ($urandom_range(0, 3) == 0);
      repeat (PHASE_TICKS) begin
        // mode mostly steady so the buttons get sampled
        if ($urandom_range(0, 19) == 0) stim_mode = ~stim_mode;
        t.prime_mode = stim_mode;
        t.up_level = ($urandom_range(0, 9) < 6);
        t.down_level = ($urandom_range(0, 9) < 6);
        t.temp_sample = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                                    : 10'($urandom_range(0, 400));
        send_tick(t);
      end
    end
  endtask

  // Receiver: random stall before taking each beat
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = pick_gap(receiver_steady);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Compare each display beat with the oldest prediction
  always @(posedge clk) begin
    display_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_displays.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none actual %h", $time, m_tdata);
      end else begin
        want = expected_displays.pop_front();
        check_field("count_value", want.count_value, m_tdata[6:0]);
        check_field("tens_segments", want.tens_segments, m_tdata[13:7]);
        check_field("units_segments", want.units_segments, m_tdata[20:14]);
        check_field("motor_on", want.motor_on, m_tdata[21]);
      end
    end
  end

  // Watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_count_wrap();
    test_prime_steps();
    test_temp_window();
    test_random_ticks();
    s_tvalid <= 1'b0;
    while (expected_displays.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/udpc_pkg.sv
hdl/updown_prime_counter_display_top.sv
hdl/udpc_checker.sv
dv/tb_top.sv
